FILE: sv/tmse_pkg.sv
package tmse_pkg;

  typedef enum logic [2:0] {
    PH_CLEAR,
    PH_IDLE,
    PH_TAPE,
    PH_TABLE,
    PH_DONE
  } phase_t;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK          = 3'd0;
  localparam status_t ST_HALTED      = 3'd1;
  localparam status_t ST_STEP_HALTED = 3'd2;
  localparam status_t ST_OVERRUN     = 3'd3;
  localparam status_t ST_BAD_ENTRY   = 3'd4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic REG_SYMBOL_COUNT = 1'b0;
  localparam logic REG_STATE_COUNT  = 1'b1;

  localparam int unsigned STEP_BITS = 48;
  localparam int unsigned POS_BITS  = 12;

endpackage

FILE: sv/turing_machine_step_engine.sv
// Turing machine step engine.
// Input beats (s_*): tuser is the operation, 0 loads one transition table entry, 1 runs
// one machine step. A load writes the entry at entry_state * symbol_count + entry_symbol.
// Every input beat gives exactly one result beat on m_*, holding the status, the symbol
// read, the entry used, the machine state, the head position and the step count.
// Each item goes from acceptance to its result register through a tape read, a table read
// through the shared state-by-symbol multiplier, then the tape write-back and state update.
// The next item is accepted in the cycle its predecessor finishes, so items never overlap;
// each item reads the tape and the table once and writes at most one of them once.
// Registers symbol_count (address 0) and state_count (address 4) sit on the APB port; the user
// must write them only while the engine is idle, which the engine itself does not enforce.
// After reset the tape is cleared one cell a cycle, all TAPE_CELLS cells (4096 by default),
// with s_tready low; register writes are taken meanwhile. The head starts in the middle of
// the tape, state and step count at zero. The transition table is not cleared.
// When m_tready is low the finished result is held in the output register; one more item
// is then accepted and worked up to its result, where it waits for the register to drain.
module turing_machine_step_engine #(
  parameter int unsigned TAPE_CELLS    = 4096,
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned SYMBOL_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // entry_state[7:0], entry_symbol[15:8], write_symbol[23:16], move_right[24],
  // next_state[32:25], zero fill
  input  logic [39:0] s_tdata,
  // operation[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], read_symbol[10:3], written_symbol[18:11], moved_right[19],
  // machine_state[27:20], head_position[39:28], step_count[87:40]
  output logic [87:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tmse_pkg::*;

  localparam int unsigned HW   = $clog2(TAPE_CELLS);
  localparam int unsigned TW   = $clog2(TABLE_ENTRIES);
  localparam int unsigned EW   = SYMBOL_BITS + 9;
  localparam int unsigned PW   = (HW > POS_BITS) ? HW : POS_BITS;
  localparam int unsigned HALF = TAPE_CELLS / 2;

  logic [7:0] symbol_count;
  logic [7:0] state_count;

  logic [SYMBOL_BITS-1:0] tape_mem [TAPE_CELLS];
  logic [EW-1:0]          table_mem [TABLE_ENTRIES];

  phase_t phase, phase_next;
  logic [HW-1:0] clr_addr;

  logic       req_op;
  logic [7:0] req_es, req_ey, req_ws, req_ns;
  logic       req_mr;

  logic [SYMBOL_BITS-1:0] tape_q;
  logic [EW-1:0]          table_q;
  logic [TW-1:0]          addr_q;
  logic                   addr_bad_q;
  logic                   sym_bad_q;

  logic [7:0]           cur_state;
  logic [HW-1:0]        head;
  logic [STEP_BITS-1:0] steps;

  logic accept, done_fire, cfg_wr;
  logic [7:0]  mul_a, mul_b, rd_sym;
  logic [15:0] tbl_sum;

  logic [SYMBOL_BITS-1:0] ent_ws;
  logic                   ent_mr;
  logic [7:0]             ent_ns;

  status_t    res_status;
  logic [7:0] res_rd, res_ws;
  logic       res_mr;
  logic       load_ok, step_commit;
  logic       halted, load_bad, overrun;
  logic [PW-1:0] pos_full;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= 8'd2;
      state_count  <= 8'd2;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_SYMBOL_COUNT: symbol_count <= pwdata[7:0];
        REG_STATE_COUNT:  state_count  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SYMBOL_COUNT: prdata = {24'd0, symbol_count};
      REG_STATE_COUNT:  prdata = {24'd0, state_count};
      default:          prdata = 32'd0;
    endcase
  end

  assign done_fire = (phase == PH_DONE) && (!m_tvalid || m_tready);
  assign s_tready  = (phase == PH_IDLE) || done_fire;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_CLEAR;
      clr_addr <= '0;
    end else begin
      phase <= phase_next;
      if (phase == PH_CLEAR) begin
        clr_addr <= clr_addr + HW'(1);
      end
    end
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_CLEAR: begin
        if (clr_addr == HW'(TAPE_CELLS - 1)) begin
          phase_next = PH_IDLE;
        end
      end
      PH_IDLE: begin
        if (accept) begin
          phase_next = PH_TAPE;
        end
      end
      PH_TAPE:  phase_next = PH_TABLE;
      PH_TABLE: phase_next = PH_DONE;
      PH_DONE: begin
        if (done_fire) begin
          phase_next = accept ? PH_TAPE : PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op <= s_tuser;
      req_es <= s_tdata[7:0];
      req_ey <= s_tdata[15:8];
      req_ws <= s_tdata[23:16];
      req_mr <= s_tdata[24];
      req_ns <= s_tdata[32:25];
    end
  end

  // shared address multiplier: state * symbol_count + symbol
  assign rd_sym  = 8'(tape_q);
  assign mul_a   = (req_op == OP_STEP) ? cur_state : req_es;
  assign mul_b   = (req_op == OP_STEP) ? rd_sym : req_ey;
  assign tbl_sum = 16'(mul_a) * 16'(symbol_count) + 16'(mul_b);

  always_ff @(posedge clk) begin
    if (phase == PH_TABLE) begin
      addr_q     <= tbl_sum[TW-1:0];
      addr_bad_q <= {1'b0, tbl_sum} >= 17'(TABLE_ENTRIES);
      sym_bad_q  <= rd_sym >= symbol_count;
    end
  end

  assign ent_ws = table_q[SYMBOL_BITS-1:0];
  assign ent_mr = table_q[SYMBOL_BITS];
  assign ent_ns = table_q[EW-1:SYMBOL_BITS+1];

  assign halted   = cur_state >= state_count;
  assign load_bad = (req_es >= state_count) || (req_ey >= symbol_count) ||
                    (req_ws >= symbol_count) || ((req_ws >> SYMBOL_BITS) != 8'd0) ||
                    addr_bad_q;
  assign overrun  = (!ent_mr && (head == '0)) ||
                    (ent_mr && (head >= HW'(TAPE_CELLS - 1)));

  always_comb begin
    res_status  = ST_OK;
    res_rd      = 8'd0;
    res_ws      = 8'd0;
    res_mr      = 1'b0;
    load_ok     = 1'b0;
    step_commit = 1'b0;
    if (req_op == OP_LOAD) begin
      if (load_bad) begin
        res_status = ST_BAD_ENTRY;
      end else begin
        load_ok    = 1'b1;
        res_status = halted ? ST_HALTED : ST_OK;
      end
    end else if (halted) begin
      res_status = ST_STEP_HALTED;
    end else if (sym_bad_q || addr_bad_q) begin
      res_status = ST_BAD_ENTRY;
      res_rd     = rd_sym;
    end else begin
      res_rd = rd_sym;
      res_ws = 8'(ent_ws);
      res_mr = ent_mr;
      if (overrun) begin
        res_status = ST_OVERRUN;
      end else begin
        step_commit = 1'b1;
        res_status  = (ent_ns >= state_count) ? ST_HALTED : ST_OK;
      end
    end
  end

  // tape: one write port shared by the clearing pass and the step write-back
  always_ff @(posedge clk) begin
    if (phase == PH_CLEAR) begin
      tape_mem[clr_addr] <= '0;
    end else if (done_fire && step_commit) begin
      tape_mem[head] <= ent_ws;
    end
    if (phase == PH_TAPE) begin
      tape_q <= tape_mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire && load_ok) begin
      table_mem[addr_q] <= {req_ns, req_mr, req_ws[SYMBOL_BITS-1:0]};
    end
    if (phase == PH_TABLE) begin
      table_q <= table_mem[tbl_sum[TW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state <= 8'd0;
      head      <= HW'(HALF);
      steps     <= '0;
    end else if (done_fire && step_commit) begin
      cur_state <= ent_ns;
      head      <= ent_mr ? head + HW'(1) : head - HW'(1);
      if (steps != '1) begin
        steps <= steps + STEP_BITS'(1);
      end
    end
  end

  // head position and state after this item
  logic [7:0]           res_state;
  logic [HW-1:0]        out_head;
  logic [STEP_BITS-1:0] out_steps;

  always_comb begin
    res_state = cur_state;
    out_head  = head;
    out_steps = steps;
    if (step_commit) begin
      res_state = ent_ns;
      out_head  = ent_mr ? head + HW'(1) : head - HW'(1);
      out_steps = (steps != '1) ? steps + STEP_BITS'(1) : steps;
    end
  end

  assign pos_full = PW'(out_head) - PW'(HALF);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      m_tdata <= {out_steps, pos_full[POS_BITS-1:0], res_state, res_mr, res_ws, res_rd,
                  res_status};
    end
  end

  a_walk : assert property (@(posedge clk) disable iff (rst)
    (accept |=> (phase == PH_TAPE) ##1 (phase == PH_TABLE) ##1 (phase == PH_DONE)))
    else $error("item did not walk through tape and table phases");

  a_no_accept_clear : assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_CLEAR) |-> !accept))
    else $error("item accepted during tape clear");

  a_head_move : assert property (@(posedge clk) disable iff (rst)
    ((!$past(rst) && !$stable(head)) |->
      $past(done_fire && (req_op == OP_STEP))))
    else $error("head moved outside a committed step");

  a_steps_inc : assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) |-> ((steps == $past(steps)) ||
                      (steps == $past(steps) + STEP_BITS'(1)))))
    else $error("step count jumped");

  a_out_rise : assert property (@(posedge clk) disable iff (rst)
    ($rose(m_tvalid) |-> $past(phase == PH_DONE)))
    else $error("result beat without a finished item");

endmodule
